### hw/rtl/htt_pkg.sv
// shared types and codes of the handle translation table
// used by htt_cell, handle_translation_table and the testbench; depends on nothing
package htt_pkg;

  localparam int unsigned HandleW = 64;

  // operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // one table entry as held in a cell
  typedef struct packed {
    logic               valid;
    logic [HandleW-1:0] key;
    logic [HandleW-1:0] value;
  } entry_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic               tok;
    logic               seen;
    logic [HandleW-1:0] data;
  } link_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic add_shift;
    logic clear;
    logic remove_op;
  } cmd_t;

endpackage

### hw/rtl/htt_cell.sv
// one slot of the handle translation table chain
// depends on htt_pkg
module htt_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  htt_pkg::cmd_t                 cmd_i,
  input  logic [htt_pkg::HandleW-1:0]   query_i,
  input  htt_pkg::entry_t               prev_i,
  input  htt_pkg::entry_t               next_i,
  input  htt_pkg::link_t                link_i,
  output htt_pkg::entry_t               entry_o,
  output htt_pkg::link_t                link_o
);
  import htt_pkg::*;

  logic               valid_q, valid_d;
  logic [HandleW-1:0] key_q, key_d;
  logic [HandleW-1:0] value_q, value_d;
  logic               tok_q, seen_q;
  logic [HandleW-1:0] cval_q;
  logic               hit;
  logic               load_next;

  assign hit       = valid_q && (key_q == query_i);
  // the matched cell and every older one pull from the next cell as the token passes
  assign load_next = tok_q && cmd_i.remove_op && (seen_q || hit);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.add_shift) begin
      valid_d = prev_i.valid;
      key_d   = prev_i.key;
      value_d = prev_i.value;
    end else if (load_next) begin
      valid_d = next_i.valid;
      key_d   = next_i.key;
      value_d = next_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= link_i.tok;
      seen_q  <= link_i.tok && link_i.seen;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    cval_q  <= link_i.data;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;

  assign link_o.tok  = tok_q;
  assign link_o.seen = seen_q || hit;
  assign link_o.data = seen_q ? cval_q : (hit ? value_q : '0);

endmodule

### hw/rtl/handle_translation_table.sv
// handle translation table: a chain of TABLE_DEPTH cells, newest entry in cell 0
// results: add and clear give their word in the cycle after acceptance; lookup and
// remove give it after a scan token, walking one cell a cycle, has left the last cell
// throughput: one add or clear per cycle while results are taken; no new word during a scan
// reset: rst_ni clears every valid bit and the token chain at once, no clearing pass
// depends on htt_pkg and htt_cell
module handle_translation_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [htt_pkg::HandleW-1:0]   key_handle_i,
  input  logic [htt_pkg::HandleW-1:0]   value_handle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [htt_pkg::HandleW-1:0]   found_value_o,
  output logic [1:0]                    status_o
);
  import htt_pkg::*;

  // controller states
  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_SCAN = 1'b1;

  logic               state_q, state_d;
  logic [1:0]         op_q;
  logic [HandleW-1:0] query_q;
  logic               out_valid_q, out_valid_d;
  logic [HandleW-1:0] found_q, found_d;
  logic [1:0]         status_q, status_d;

  logic   accept;
  logic   scan_op;
  logic   full;
  logic   scan_done;
  cmd_t   cmd;
  entry_t new_entry;
  entry_t empty_entry;

  entry_t entries [TABLE_DEPTH];
  link_t  links   [TABLE_DEPTH+1];

  logic [TABLE_DEPTH-1:0] valid_vec;
  logic [TABLE_DEPTH-1:0] tok_vec;

  // a word is taken only with no scan running and the output slot free or draining
  assign in_ready_o = (state_q == STATE_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign scan_op    = operation_i inside {OP_LOOKUP, OP_REMOVE};

  // entries stay packed from cell 0, so the last cell tells whether the table is full
  assign full = entries[TABLE_DEPTH-1].valid;

  assign cmd.add_shift = accept && (operation_i == OP_ADD) && !full;
  assign cmd.clear     = accept && (operation_i == OP_CLEAR);
  assign cmd.remove_op = (op_q == OP_REMOVE);

  assign new_entry.valid   = 1'b1;
  assign new_entry.key     = key_handle_i;
  assign new_entry.value   = value_handle_i;
  assign empty_entry.valid = 1'b0;
  assign empty_entry.key   = '0;
  assign empty_entry.value = '0;

  // the token enters cell 0 at the acceptance edge of a lookup or remove
  assign links[0].tok  = accept && scan_op;
  assign links[0].seen = 1'b0;
  assign links[0].data = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    entry_t prev_e, next_e;
    if (g == 0) begin : g_first
      assign prev_e = new_entry;
    end else begin : g_mid_prev
      assign prev_e = entries[g-1];
    end
    if (g == TABLE_DEPTH-1) begin : g_last
      assign next_e = empty_entry;
    end else begin : g_mid_next
      assign next_e = entries[g+1];
    end

    htt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .query_i (query_q),
      .prev_i  (prev_e),
      .next_i  (next_e),
      .link_i  (links[g]),
      .entry_o (entries[g]),
      .link_o  (links[g+1])
    );

    assign valid_vec[g] = entries[g].valid;
    assign tok_vec[g]   = links[g+1].tok;
  end

  // token leaving the last cell carries the scan verdict
  assign scan_done = (state_q == STATE_SCAN) && links[TABLE_DEPTH].tok;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    status_d    = status_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      STATE_IDLE: begin
        if (accept) begin
          if (scan_op) begin
            state_d = STATE_SCAN;
          end else begin
            // add and clear finish at once
            out_valid_d = 1'b1;
            found_d     = '0;
            status_d    = ((operation_i == OP_ADD) && full) ? STAT_FULL : STAT_OK;
          end
        end
      end
      STATE_SCAN: begin
        if (scan_done) begin
          state_d     = STATE_IDLE;
          out_valid_d = 1'b1;
          found_d     = ((op_q == OP_LOOKUP) && links[TABLE_DEPTH].seen)
                        ? links[TABLE_DEPTH].data : '0;
          status_d    = links[TABLE_DEPTH].seen ? STAT_OK : STAT_MISS;
        end
      end
      default: begin
        state_d = STATE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_IDLE;
      out_valid_q <= 1'b0;
      op_q        <= OP_ADD;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        op_q <= operation_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    status_q <= status_d;
    if (accept) begin
      query_q <= key_handle_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_value_o = found_q;
  assign status_o      = status_q;

  // at most one scan token in the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok_vec))
    else $error("more than one scan token in the chain");

  // no token while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == STATE_IDLE) |-> (tok_vec == '0))
    else $error("scan token present while idle");

  // valid entries stay packed toward cell 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("table entries not packed");

  // an add to a full table is flagged and leaves the table as it was
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i == OP_ADD) && full)
      |=> (out_valid_q && (status_q == STAT_FULL) && $stable(valid_vec)))
    else $error("add to full table not flagged");

  // clear empties the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i == OP_CLEAR)) |=> (valid_vec == '0))
    else $error("clear left valid entries");

endmodule

### sim/testbench.sv
// self-checking testbench for the handle translation table
// runs directed and random add, lookup, remove and clear words; depends on htt_pkg and handle_translation_table
`timescale 1ns / 100ps

module testbench;
  import htt_pkg::*;

  localparam int unsigned TBL_DEPTH = 16;
  // lookup and remove can take a full table scan, so allow plenty of headroom
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned POOL_SIZE = 12;

  typedef logic [HandleW-1:0] handle_t;

  // one expected result word
  typedef struct packed {
    handle_t    found;
    logic [1:0] status;
  } xlate_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [1:0] operation = OP_ADD;
  handle_t    key_handle = '0;
  handle_t    value_handle = '0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  handle_t    found_value;
  logic [1:0] status;

  // predicted table contents, slot 0 oldest, slot table_count-1 newest
  handle_t    table_keys [TBL_DEPTH];
  handle_t    table_vals [TBL_DEPTH];
  int         table_count = 0;

  // results still owed by the block, oldest first
  xlate_result_t pending_results [$];

  int         mismatch_count = 0;
  int         cycle_count = 0;
  // when set, neither side inserts random idles
  logic       no_idle = 1'b0;

  handle_translation_table #(
    .TABLE_DEPTH    (TBL_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .key_handle_i   (key_handle),
    .value_handle_i (value_handle),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .found_value_o  (found_value),
    .status_o       (status)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run guard, in case a handshake never completes
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side back-pressure: out_ready drops at random with a 6 percent chance, never while no_idle is set
  always @(posedge clk_i) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 6);
  end

  function automatic handle_t rand_handle();
    return {$urandom(), $urandom()};
  endfunction

  // apply one operation to the predicted table and return the word it yields
  function automatic xlate_result_t translate_op(input logic [1:0] op, input handle_t key,
                                                 input handle_t val);
    xlate_result_t res;
    int hit;
    res.found = '0;
    res.status = STAT_OK;
    // newest matching slot, -1 on a miss; only live slots are compared
    hit = -1;
    for (int s = table_count - 1; s >= 0; s--) begin
      if (hit < 0 && table_keys[s] == key) hit = s;
    end
    case (op)
      OP_ADD: begin
        if (table_count >= TBL_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          table_keys[table_count] = key;
          table_vals[table_count] = val;
          table_count++;
        end
      end
      OP_LOOKUP: begin
        if (hit >= 0) res.found = table_vals[hit];
        else res.status = STAT_MISS;
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          // newer entries slide down one slot so order is kept
          for (int s = hit; s + 1 < table_count; s++) begin
            table_keys[s] = table_keys[s + 1];
            table_vals[s] = table_vals[s + 1];
          end
          table_count--;
        end else begin
          res.status = STAT_MISS;
        end
      end
      default: begin
        table_count = 0;
      end
    endcase
    return res;
  endfunction

  // compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    xlate_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: found %h status %0d", found_value, status);
      end else begin
        want = pending_results.pop_front();
        if (found_value !== want.found || status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected found %h status %0d, got found %h status %0d",
                     want.found, want.status, found_value, status);
        end
      end
    end
  end

  // send one word; the prediction is made at the edge that accepts it
  task automatic send_word(input logic [1:0] op, input handle_t key, input handle_t val);
    int gap;
    if (!no_idle && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    operation <= op;
    key_handle <= key;
    value_handle <= val;
    do @(posedge clk_i); while (!in_ready);
    pending_results.push_back(translate_op(op, key, val));
  endtask

  // hold off the sender until every owed word has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // lookup and remove on an empty table both miss
  task automatic test_empty_table();
    send_word(OP_LOOKUP, '0, '1);
    send_word(OP_REMOVE, '1, '0);
  endtask

  // extreme keys and values through add, lookup and remove
  task automatic test_add_lookup_remove();
    send_word(OP_ADD, '0, '0);
    send_word(OP_ADD, '1, '1);
    send_word(OP_LOOKUP, '1, '0);
    send_word(OP_LOOKUP, '0, '1);
    send_word(OP_REMOVE, 64'h5555_aaaa_5555_aaaa, '0);
    send_word(OP_LOOKUP, 64'haaaa_5555_aaaa_5555, '0);
  endtask

  // a newer duplicate shadows the older one until it is removed
  task automatic test_duplicate_keys();
    send_word(OP_ADD, '0, 64'h0123_4567_89ab_cdef);
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_REMOVE, '0, '0);
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_REMOVE, '0, '0);
    send_word(OP_LOOKUP, '0, '0);
  endtask

  // fill to capacity, then one more add is dropped
  task automatic test_full_table();
    send_word(OP_CLEAR, '0, '0);
    for (int n = 0; n < TBL_DEPTH; n++) send_word(OP_ADD, rand_handle(), rand_handle());
    send_word(OP_ADD, '1, '1);
    send_word(OP_LOOKUP, '1, '0);
  endtask

  // clear empties the table; an earlier key no longer hits
  task automatic test_clear();
    send_word(OP_ADD, 64'hdead_beef_0000_0001, '1);
    send_word(OP_CLEAR, '1, '1);
    send_word(OP_LOOKUP, 64'hdead_beef_0000_0001, '0);
  endtask

  // random mix over a small key pool so lookups and removes mostly hit
  task automatic test_random_mix(input int n_items);
    handle_t    key_pool [POOL_SIZE];
    handle_t    key;
    logic [1:0] op;
    int         add_pct;
    int         pick;
    add_pct = 50;
    for (int k = 0; k < POOL_SIZE; k++) key_pool[k] = rand_handle();
    for (int n = 0; n < n_items; n++) begin
      // one long stretch with no random idles on either side
      no_idle = (n >= 700 && n < 1100);
      // swing the add share so the table both fills up and drains
      if (n % 150 == 0) add_pct = $urandom_range(20, 70);
      // now and then let the pipeline run dry before going on
      if (n % 400 == 399) wait_for_results();
      if ($urandom_range(0, 9) == 0) key_pool[$urandom_range(0, POOL_SIZE - 1)] = rand_handle();
      pick = $urandom_range(0, 99);
      if (pick < 2) op = OP_CLEAR;
      else if (pick < 2 + add_pct) op = OP_ADD;
      else if (pick < 2 + add_pct + (98 - add_pct) / 2) op = OP_LOOKUP;
      else op = OP_REMOVE;
      key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : rand_handle();
      send_word(op, key, rand_handle());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_add_lookup_remove();
    test_duplicate_keys();
    test_full_table();
    test_clear();
    wait_for_results();
    test_random_mix(1880);

    // drain, then give a stray word time to show up
    wait_for_results();
    repeat (2 * TBL_DEPTH + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
